// ----- design/ctfd_pkg.sv -----
// Package for the CAN tunnel frame deframer.
// Holds the frame phase type and the shared constants; it depends on nothing else.
package ctfd_pkg;

   // Default for the largest payload that a frame may carry.
   localparam int MAX_PAYLOAD_DEF = 64;

   localparam int ID_BYTES = 4;
   localparam int RTR_BIT  = 30;
   localparam int FD_BIT   = 7;

   typedef enum logic [1:0] {
      PH_ID    = 2'd0,
      PH_LEN   = 2'd1,
      PH_FLAGS = 2'd2,
      PH_DATA  = 2'd3
   } phase_type;

endpackage

// ----- design/can_tunnel_frame_deframer.sv -----
// Top level of the CAN tunnel frame deframer: the header parser and the result register.
// Depends on ctfd_pkg for the phase type and the constants.
//
//   channel | direction | words carried
//   --------+-----------+--------------------------------------------------------
//   req_    | in        | one byte of the tunnelled frame stream
//   rsp_    | out       | one header-only, error or payload-byte result per word
//
// One input word is taken every cycle while req_tready is high. Each word is parsed
// in the cycle of its acceptance and any result lands in the output register on the
// same edge, so it is visible in the next cycle. The output register is refilled
// in the cycle in which its word is taken, hence a stall on rsp_ holds req_tready
// low only while the register is full and not being drained. Reset is synchronous and
// returns the parser to the identifier phase with an empty output register.
module can_tunnel_frame_deframer
   import ctfd_pkg::*;
#(
   parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] frame_id, [39:32] raw_len, [40] is_fd, [48:41] fd_flags,
   // [56:49] data_byte, [62:57] byte_index, [63] zero
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // [0] has_data, [1] error
);

   localparam logic [6:0] MAX_LEN = 7'(MaxPayload);

   phase_type   phase_ff, phase_in;
   logic [6:0]  count_ff, count_in;
   logic [31:0] id_ff, id_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  flags_ff, flags_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   logic        accept;
   logic        header_done;
   logic        classic;
   logic [7:0]  len_eff;
   logic [7:0]  flags_eff;
   logic [6:0]  dlen;
   logic [6:0]  count_next;
   logic        emit;
   logic        emit_len_zero;
   logic        emit_error;
   logic        emit_data;
   logic        data_last;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Header fields as they stand once the current byte has been taken.
   always_comb begin
      len_eff     = len_ff;
      flags_eff   = flags_ff;
      header_done = 1'b0;
      classic     = 1'b0;
      unique case (phase_ff)
         PH_LEN: begin
            len_eff = req_tdata;
            if (!req_tdata[FD_BIT]) begin
               flags_eff   = 8'd0;
               header_done = 1'b1;
               classic     = 1'b1;
            end
         end
         PH_FLAGS: begin
            flags_eff   = req_tdata;
            header_done = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign dlen       = len_eff[6:0];
   assign count_next = count_ff + 7'd1;
   assign data_last  = count_next >= dlen;

   // Next state of the parser.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      id_in    = id_ff;
      len_in   = len_eff;
      flags_in = flags_eff;
      unique case (phase_ff)
         PH_ID: begin
            id_in = {id_ff[23:0], req_tdata};
            if (count_next >= 7'(ID_BYTES)) begin
               count_in = 7'd0;
               phase_in = PH_LEN;
            end else begin
               count_in = count_next;
            end
         end
         PH_LEN, PH_FLAGS: begin
            if (header_done) begin
               count_in = 7'd0;
               if (id_ff[RTR_BIT]) begin
                  phase_in = PH_ID;
                  if (classic) begin
                     len_in = 8'd0;
                  end
               end else if (dlen == 7'd0 || dlen > MAX_LEN) begin
                  phase_in = PH_ID;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               phase_in = PH_FLAGS;
            end
         end
         PH_DATA: begin
            if (data_last) begin
               phase_in = PH_ID;
               count_in = 7'd0;
            end else begin
               count_in = count_next;
            end
         end
         default: begin
         end
      endcase
   end

   // Result word for the current byte.
   always_comb begin
      emit          = 1'b0;
      emit_len_zero = 1'b0;
      emit_error    = 1'b0;
      emit_data     = 1'b0;
      unique case (phase_ff)
         PH_LEN, PH_FLAGS: begin
            if (header_done) begin
               if (id_ff[RTR_BIT]) begin
                  emit          = 1'b1;
                  emit_len_zero = classic;
               end else if (dlen == 7'd0) begin
                  emit = 1'b1;
               end else if (dlen > MAX_LEN) begin
                  emit       = 1'b1;
                  emit_error = 1'b1;
               end
            end
         end
         PH_DATA: begin
            emit      = 1'b1;
            emit_data = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_data_in        = 64'd0;
      rsp_data_in[31:0]  = id_ff;
      rsp_data_in[39:32] = emit_len_zero ? 8'd0 : len_eff;
      rsp_data_in[40]    = emit_len_zero ? 1'b0 : len_eff[FD_BIT];
      rsp_data_in[48:41] = flags_eff;
      rsp_data_in[56:49] = emit_data ? req_tdata : 8'd0;
      rsp_data_in[62:57] = emit_data ? count_ff[5:0] : 6'd0;
      rsp_last_in        = emit_data ? data_last : 1'b1;
      rsp_user_in        = {emit_error, emit_data};

      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ID;
         count_ff     <= 7'd0;
         id_ff        <= 32'd0;
         len_ff       <= 8'd0;
         flags_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            id_ff    <= id_in;
            len_ff   <= len_in;
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- verif/can_tunnel_frame_deframer_chk.sv -----
`timescale 1ns / 1ps
// Checker for the CAN tunnel frame deframer: follows the byte stream on req_, predicts
// every result word and compares it with what leaves on rsp_. Depends on ctfd_pkg.
module can_tunnel_frame_deframer_chk
   import ctfd_pkg::*;
#(
   parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] frame_id, [39:32] raw_len, [40] is_fd, [48:41] fd_flags,
   // [56:49] data_byte, [62:57] byte_index, [63] zero
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [1:0]  rsp_tuser,    // [0] has_data, [1] error
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic [31:0] frame_id;
      logic [7:0]  raw_len;
      logic        is_fd;
      logic [7:0]  fd_flags;
      logic        has_data;
      logic [7:0]  data_byte;
      logic [5:0]  byte_index;
      logic        last;
      logic        error;
   } frame_result_type;

   phase_type        phase = PH_ID;
   logic [6:0]       byte_cnt = '0;
   logic [31:0]      id_acc = '0;
   logic [7:0]       len_byte = '0;
   logic [7:0]       flag_byte = '0;
   frame_result_type pending_results[$];
   int               mismatches = 0;

   assign fail_count = mismatches;

   function automatic string describe(frame_result_type r);
      return $sformatf("id %h len %h fd %b flags %h data %b:%h idx %0d last %b err %b",
                       r.frame_id, r.raw_len, r.is_fd, r.fd_flags, r.has_data,
                       r.data_byte, r.byte_index, r.last, r.error);
   endfunction

   function automatic void push_result(logic has_data, logic [7:0] data, logic [5:0] idx,
                                       logic last, logic err);
      frame_result_type r;
      r.frame_id   = id_acc;
      r.raw_len    = len_byte;
      r.is_fd      = len_byte[FD_BIT];
      r.fd_flags   = flag_byte;
      r.has_data   = has_data;
      r.data_byte  = data;
      r.byte_index = idx;
      r.last       = last;
      r.error      = err;
      pending_results.push_back(r);
   endfunction

   // Runs once the header is complete, after the length byte of a classic frame or
   // after the flags byte of an FD frame.
   function automatic void close_header(logic classic);
      logic [6:0] dlen;
      dlen = len_byte[6:0];
      phase = PH_ID;
      byte_cnt = '0;
      if (id_acc[RTR_BIT]) begin
         // A classic remote request reports its length as zero.
         if (classic) len_byte = '0;
         push_result(1'b0, 8'h00, 6'd0, 1'b1, 1'b0);
      end else if (dlen == 7'd0) begin
         push_result(1'b0, 8'h00, 6'd0, 1'b1, 1'b0);
      end else if (int'(dlen) > MaxPayload) begin
         push_result(1'b0, 8'h00, 6'd0, 1'b1, 1'b1);
      end else begin
         phase = PH_DATA;
      end
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      logic [6:0] dlen;
      logic       is_last;
      case (phase)
         PH_ID: begin
            id_acc = {id_acc[23:0], b};
            byte_cnt = byte_cnt + 7'd1;
            if (int'(byte_cnt) >= ID_BYTES) begin
               byte_cnt = '0;
               phase = PH_LEN;
            end
         end
         PH_LEN: begin
            len_byte = b;
            if (b[FD_BIT]) begin
               phase = PH_FLAGS;
            end else begin
               flag_byte = '0;
               close_header(1'b1);
            end
         end
         PH_FLAGS: begin
            flag_byte = b;
            close_header(1'b0);
         end
         default: begin
            dlen = len_byte[6:0];
            is_last = ({1'b0, byte_cnt} + 8'd1) >= {1'b0, dlen};
            push_result(1'b1, b, byte_cnt[5:0], is_last, 1'b0);
            if (is_last) begin
               phase = PH_ID;
               byte_cnt = '0;
            end else begin
               byte_cnt = byte_cnt + 7'd1;
            end
         end
      endcase
   endfunction

   function automatic void check_result();
      frame_result_type got;
      frame_result_type want;
      got.frame_id   = rsp_tdata[31:0];
      got.raw_len    = rsp_tdata[39:32];
      got.is_fd      = rsp_tdata[40];
      got.fd_flags   = rsp_tdata[48:41];
      got.data_byte  = rsp_tdata[56:49];
      got.byte_index = rsp_tdata[62:57];
      got.has_data   = rsp_tuser[0];
      got.error      = rsp_tuser[1];
      got.last       = rsp_tlast;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result word with nothing expected: %s", $realtime, describe(got));
      end else begin
         want = pending_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result mismatch", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      end
   endfunction

   // Results are checked before the byte of the same edge is parsed, since a word
   // leaving the block was always predicted from an earlier byte.
   always @(posedge clock) begin
      if (reset) begin
         phase = PH_ID;
         byte_cnt = '0;
         id_acc = '0;
         len_byte = '0;
         flag_byte = '0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) deframe_byte(req_tdata);
      end
      outstanding <= pending_results.size();
   end

endmodule

// ----- verif/can_tunnel_frame_deframer_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the CAN tunnel frame deframer: drives directed and random frame
// streams with random idling on both sides. Depends on the block, ctfd_pkg and the checker.
module can_tunnel_frame_deframer_tb
   import ctfd_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   int          fail_count;
   int          outstanding;
   int          bytes_sent = 0;
   bit          steady = 1'b0;

   can_tunnel_frame_deframer u_dut (.*);

   can_tunnel_frame_deframer_chk u_chk (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // The receiver stalls at random except in the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 30);
   end

   task automatic send_byte(input logic [7:0] b);
      steady = (bytes_sent >= 400 && bytes_sent < 700);
      while (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Sends a whole frame; the payload follows only where the header calls for one.
   task automatic send_frame(input logic [31:0] id, input logic [7:0] len,
                             input logic [7:0] flags);
      int dlen;
      dlen = int'(len[6:0]);
      for (int i = 3; i >= 0; i--) send_byte(id[8*i +: 8]);
      send_byte(len);
      if (len[FD_BIT]) send_byte(flags);
      if (!id[RTR_BIT] && dlen <= MAX_PAYLOAD_DEF) begin
         for (int i = 0; i < dlen; i++) send_byte(8'($urandom));
      end
   endtask

   task automatic random_frame();
      logic [31:0] id;
      logic [7:0]  len;
      int          dlen;
      int          pick;
      id = $urandom;
      id[RTR_BIT] = ($urandom_range(99) < 15);
      pick = $urandom_range(99);
      if (pick < 8) dlen = 0;
      else if (pick < 70) dlen = $urandom_range(8, 1);
      else if (pick < 92) dlen = $urandom_range(63, 9);
      else if (pick < 95) dlen = 64;
      else dlen = $urandom_range(127, 65);
      len = {($urandom_range(99) < 40) ? 1'b1 : 1'b0, 7'(dlen)};
      send_frame(id, len, 8'($urandom));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_frame(32'hFFFF_FFFF, 8'h0F, 8'h00);   // classic remote request
      send_frame(32'h0000_0000, 8'h00, 8'h00);   // empty payload
      send_frame(32'h4000_0001, 8'hC5, 8'hFF);   // FD remote request, length ignored
      send_frame(32'h0000_007F, 8'h41, 8'h00);   // one byte over the payload limit
      send_frame(32'h8000_0000, 8'h81, 8'hA5);   // FD frame with a single data byte

      // Mostly whole frames; now and then a few stray words knock the framing off.
      while (bytes_sent < 1100) begin
         if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
         end else begin
            random_frame();
         end
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/ctfd_pkg.sv
design/can_tunnel_frame_deframer.sv
verif/can_tunnel_frame_deframer_chk.sv
verif/can_tunnel_frame_deframer_tb.sv
